// ----- design/sci_pkg.sv -----
// Shared types, constants and the status line character function.
package sci_pkg;

  localparam logic [7:0] SERVO_MAX   = 8'd184;
  localparam logic [7:0] SERVO_MIN   = 8'd39;
  localparam logic [7:0] SERVO_RESET = 8'd111;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam int LINE_LEN = 13;
  localparam logic [3:0] LAST_IDX = 4'(LINE_LEN - 1);

  // Values captured for one status line.
  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] pos_one;
    logic [7:0] pos_two;
    logic [7:0] pos_three;
  } line_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h37 + {4'd0, nib};
    end
    return c;
  endfunction

  function automatic logic [7:0] line_char(input line_t l, input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = hex_char(l.addr[7:4]);
      4'd1:    c = hex_char(l.addr[3:0]);
      4'd3:    c = hex_char(l.pos_one[7:4]);
      4'd4:    c = hex_char(l.pos_one[3:0]);
      4'd6:    c = hex_char(l.pos_two[7:4]);
      4'd7:    c = hex_char(l.pos_two[3:0]);
      4'd9:    c = hex_char(l.pos_three[7:4]);
      4'd10:   c = hex_char(l.pos_three[3:0]);
      4'd11:   c = CHAR_CR;
      4'd12:   c = CHAR_LF;
      default: c = CHAR_COMMA;
    endcase
    return c;
  endfunction

endpackage

// ----- design/sci_front.sv -----
// Command decoder: removes the address offset, steps the servo positions
// and pushes a snapshot for each status request.
module sci_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            device_address,
  input  logic                  rx_valid,
  output logic                  rx_stall,
  input  logic [7:0]            rx_byte,
  input  sci_pkg::queue_status_t q_status,
  output logic                  push,
  output sci_pkg::line_t        push_line
);

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_UP,
    CMD_DOWN,
    CMD_STATUS
  } cmd_kind_t;

  localparam logic [7:0] CMD_A_UP   = 8'h41;
  localparam logic [7:0] CMD_B_UP   = 8'h42;
  localparam logic [7:0] CMD_C_UP   = 8'h43;
  localparam logic [7:0] CMD_D_UP   = 8'h44;
  localparam logic [7:0] CMD_A_DOWN = 8'h61;
  localparam logic [7:0] CMD_B_DOWN = 8'h62;
  localparam logic [7:0] CMD_C_DOWN = 8'h63;
  localparam logic [7:0] CMD_D_DOWN = 8'h64;

  logic [7:0] pos_one;
  logic [7:0] pos_two;
  logic [7:0] pos_three;
  logic [7:0] offset;
  logic [7:0] cmd;
  logic       accept;
  cmd_kind_t  kind;
  logic [2:0] target;

  assign offset   = {device_address[5:0], 2'b00};
  assign cmd      = rx_byte - offset;
  assign rx_stall = q_status.full;
  assign accept   = rx_valid && !rx_stall;

  // A byte below the offset would wrap, so it matches nothing.
  always_comb begin
    kind   = CMD_NONE;
    target = 3'b000;
    if (rx_byte >= offset) begin
      unique case (cmd) inside
        CMD_A_UP:   begin kind = CMD_UP;   target = 3'b001; end
        CMD_B_UP:   begin kind = CMD_UP;   target = 3'b010; end
        CMD_C_UP:   begin kind = CMD_UP;   target = 3'b100; end
        CMD_A_DOWN: begin kind = CMD_DOWN; target = 3'b001; end
        CMD_B_DOWN: begin kind = CMD_DOWN; target = 3'b010; end
        CMD_C_DOWN: begin kind = CMD_DOWN; target = 3'b100; end
        CMD_D_UP, CMD_D_DOWN: kind = CMD_STATUS;
        default:    kind = CMD_NONE;
      endcase
    end
  end

  function automatic logic [7:0] stepped(input logic [7:0] p, input cmd_kind_t k);
    logic [7:0] r;
    r = p;
    if (k == CMD_UP && p < sci_pkg::SERVO_MAX) begin
      r = p + 8'd1;
    end else if (k == CMD_DOWN && p > sci_pkg::SERVO_MIN) begin
      r = p - 8'd1;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_one   <= sci_pkg::SERVO_RESET;
      pos_two   <= sci_pkg::SERVO_RESET;
      pos_three <= sci_pkg::SERVO_RESET;
    end else if (accept) begin
      if (target[0]) begin
        pos_one <= stepped(pos_one, kind);
      end
      if (target[1]) begin
        pos_two <= stepped(pos_two, kind);
      end
      if (target[2]) begin
        pos_three <= stepped(pos_three, kind);
      end
    end
  end

  assign push                = accept && (kind == CMD_STATUS);
  assign push_line.addr      = device_address;
  assign push_line.pos_one   = pos_one;
  assign push_line.pos_two   = pos_two;
  assign push_line.pos_three = pos_three;

endmodule

// ----- design/sci_queue.sv -----
// Short queue of pending status line snapshots.
module sci_queue #(
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  sci_pkg::line_t         push_line,
  input  logic                   pop,
  output sci_pkg::line_t         head_line,
  output sci_pkg::queue_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  sci_pkg::line_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_line;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  assign head_line        = entries[rd_ptr];
  assign status.full      = (count == FULL_COUNT);
  assign status.not_empty = (count != '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && count == FULL_COUNT))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && count == '0))
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("queue count beyond depth");

endmodule

// ----- design/sci_back.sv -----
// Status line serializer: sends one character word per cycle while tx_stall is low, from a registered output.
module sci_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_not_empty,
  input  sci_pkg::line_t head_line,
  output logic           pop,
  output logic           tx_valid,
  input  logic           tx_stall,
  output logic [7:0]     tx_char,
  output logic           last_char
);

  sci_pkg::line_t line;
  logic           active;
  logic [3:0]     idx;
  logic           out_free;

  assign out_free = !tx_valid || !tx_stall;
  assign pop      = out_free && !active && q_not_empty;

  // The first character is taken straight from the queue head, so lines
  // follow each other with no gap.
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
      active   <= 1'b0;
      idx      <= '0;
    end else if (out_free) begin
      if (active) begin
        tx_valid  <= 1'b1;
        tx_char   <= sci_pkg::line_char(line, idx);
        last_char <= (idx == sci_pkg::LAST_IDX);
        idx       <= idx + 4'd1;
        if (idx == sci_pkg::LAST_IDX) begin
          active <= 1'b0;
        end
      end else if (q_not_empty) begin
        tx_valid  <= 1'b1;
        tx_char   <= sci_pkg::line_char(head_line, 4'd0);
        last_char <= 1'b0;
        line      <= head_line;
        idx       <= 4'd1;
        active    <= 1'b1;
      end else begin
        tx_valid <= 1'b0;
      end
    end
  end

  a_last_is_lf: assert property (@(posedge clk) disable iff (rst)
    tx_valid && last_char |-> tx_char == sci_pkg::CHAR_LF)
    else $error("last character is not LF");

  a_no_pop_mid_line: assert property (@(posedge clk) disable iff (rst)
    active |-> !pop)
    else $error("queue popped while a line is in progress");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    tx_valid && last_char && !tx_stall |-> !active)
    else $error("line still active after its last character");

endmodule

// ----- design/servo_command_interpreter.sv -----
// Top level: configuration register, command decoder, snapshot queue and serializer.
// A command word is accepted in any cycle unless the snapshot queue is full.
// Servo steps take effect at the accepting edge; a status request gives 13
// character words: the snapshot is queued, the serializer loads the first into tx_char
// once earlier lines are sent, then one per cycle while tx_stall is low.
// Synchronous reset sets positions to 111, the address to 0 and empties the queue.
module servo_command_interpreter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        tx_valid,
  input  logic        tx_stall,
  output logic [7:0]  tx_char,
  output logic        last_char
);

  localparam logic [2:0] ADDR_DEVICE_ADDRESS = 3'h0;

  logic [7:0]             device_address;
  logic                   push;
  logic                   pop;
  sci_pkg::line_t         push_line;
  sci_pkg::line_t         head_line;
  sci_pkg::queue_status_t q_status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'd0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_DEVICE_ADDRESS) begin
      device_address <= pwdata[7:0];
    end
  end

  assign prdata = (paddr == ADDR_DEVICE_ADDRESS) ? {24'd0, device_address} : 32'd0;

  sci_front u_front (
    .clk            (clk),
    .rst            (rst),
    .device_address (device_address),
    .rx_valid       (rx_valid),
    .rx_stall       (rx_stall),
    .rx_byte        (rx_byte),
    .q_status       (q_status),
    .push           (push),
    .push_line      (push_line)
  );

  sci_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_line (push_line),
    .pop       (pop),
    .head_line (head_line),
    .status    (q_status)
  );

  sci_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_status.not_empty),
    .head_line   (head_line),
    .pop         (pop),
    .tx_valid    (tx_valid),
    .tx_stall    (tx_stall),
    .tx_char     (tx_char),
    .last_char   (last_char)
  );

endmodule
